// ===== design/cwig_pkg.sv =====
// Shared widths, field types and register codes of the clipped window index generator.
package cwig_pkg;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int COORD_IN_W = 11;
    localparam int SIZE_W     = 3;
    localparam int HALF_W     = 2;
    localparam int IMG_W      = 21;
    localparam int TAP_W      = 6;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS = 1'b0,
        REG_IMAGE_COLS = 1'b1
    } cfg_reg_t;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [TAP_W-1:0]  tap_t;
    typedef logic [IMG_W-1:0]  img_t;

endpackage

// ===== design/clipped_window_index_generator.sv =====
// Clipped window index generator: walks a filter window clipped to the image.
//
// Slave stream s_*: one word per window (centre x, centre y, filter size).
// Master stream m_*: one word per pixel of the clipped window, image index
// and flipped tap index, x outer and y inner, tlast on the final pair.
// Configuration: cfg_we with cfg_index 0 (image rows) or 1 (image columns).
// A value of 0 acts as 1, a value above MAX_IMAGE_DIM acts as MAX_IMAGE_DIM.
// Write only while idle.
// Timing: a word is taken while the walker is idle; a set-up state follows,
// then, while m_tready does not stall the output, one pair per cycle enters a
// three-register pipeline (operand, product, output). The next word is taken
// only once the walker has stepped through the whole clipped window (1 to 49
// pixels) and is idle again.
// Reset: image size 64 x 64, walker idle, pipeline empty.
// Stall: while m_tready is low with m_tvalid high, the whole pipeline and the
// window walk hold (a new word is still taken); no pair is lost or repeated.
module clipped_window_index_generator #(
    parameter int MAX_FILTER_SIZE = 7,
    parameter int MAX_IMAGE_DIM   = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: center_x[10:0], center_y[21:11], filter_size[24:22], zero pad
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cwig_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: image_index[20:0], tap_index[26:21], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cwig_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [cwig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cwig_pkg::CFG_W-1:0]    cfg_data
);
    import cwig_pkg::*;

    localparam int DIM_W  = $clog2(MAX_IMAGE_DIM + 1);
    localparam int XW     = DIM_W + 1;
    localparam int PROD_W = 2 * DIM_W;
    localparam int SUM_W  = PROD_W + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_WALK} state_t;

    function automatic logic [DIM_W-1:0] dim_eff(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
            r = DIM_W'(1);
        else if (32'(d) > 32'(MAX_IMAGE_DIM))
            r = DIM_W'(MAX_IMAGE_DIM);
        else
            r = DIM_W'(d);
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_c(input logic [COORD_IN_W-1:0] c,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (c == '0)
            r = DIM_W'(1);
        else if (32'(c) > 32'(lim))
            r = lim;
        else
            r = DIM_W'(c);
        return r;
    endfunction

    state_t           state_reg;
    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [DIM_W-1:0] cx_reg, cy_reg;
    size_t            size_reg;
    half_t            half_reg;
    logic [DIM_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [DIM_W-1:0] walk_x_reg, walk_y_reg;

    // pipeline stage 1: operands
    logic             v1_reg;
    logic [DIM_W-1:0] xm1_1_reg, ym1_1_reg, rows_1_reg;
    size_t            tx_1_reg, ty_1_reg, size_1_reg;
    logic             fin_1_reg;
    // pipeline stage 2: product
    logic              v2_reg;
    logic [PROD_W-1:0] prod_2_reg;
    logic [DIM_W-1:0]  xm1_2_reg;
    tap_t              tap_2_reg;
    logic              fin_2_reg;
    // output register
    logic              out_valid_reg;
    img_t              img_reg;
    tap_t              tap_reg;
    logic              last_reg;

    logic             adv;
    logic             emit;
    logic             fin;
    size_t            in_size, size_next;
    logic [XW-1:0]    cxh, cyh;
    logic [XW-1:0]    tx_full, ty_full;
    logic [SUM_W-1:0] img_sum;

    assign adv      = !out_valid_reg || m_tready;
    assign emit     = (state_reg == ST_WALK) && adv;
    assign fin      = (walk_x_reg == x1_reg) && (walk_y_reg == y1_reg);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        in_size = s_tdata[24:22];
        if (in_size == '0)
            size_next = SIZE_W'(1);
        else if (32'(in_size) > 32'(MAX_FILTER_SIZE))
            size_next = SIZE_W'(MAX_FILTER_SIZE);
        else
            size_next = in_size;
    end

    assign cxh     = XW'(cx_reg) + XW'(half_reg);
    assign cyh     = XW'(cy_reg) + XW'(half_reg);
    assign tx_full = cxh - XW'(walk_x_reg);
    assign ty_full = cyh - XW'(walk_y_reg);
    assign img_sum = SUM_W'(prod_2_reg) + SUM_W'(xm1_2_reg) + SUM_W'(1);

    // control and window walker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rows_reg  <= DIM_W'(64);
            cols_reg  <= DIM_W'(64);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_ROWS: rows_reg <= dim_eff(cfg_data);
                    REG_IMAGE_COLS: cols_reg <= dim_eff(cfg_data);
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_SETUP;
                end
                ST_SETUP:
                    state_reg <= ST_WALK;
                ST_WALK:
                begin
                    if (adv && fin)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            cx_reg   <= clamp_c(s_tdata[10:0], rows_reg);
            cy_reg   <= clamp_c(s_tdata[21:11], cols_reg);
            size_reg <= size_next;
            half_reg <= HALF_W'((size_next - SIZE_W'(1)) >> 1);
        end
        if (state_reg == ST_SETUP)
        begin
            x0_reg     <= (cx_reg > DIM_W'(half_reg)) ? cx_reg - DIM_W'(half_reg) : DIM_W'(1);
            y0_reg     <= (cy_reg > DIM_W'(half_reg)) ? cy_reg - DIM_W'(half_reg) : DIM_W'(1);
            x1_reg     <= (cxh > XW'(rows_reg)) ? rows_reg : DIM_W'(cxh);
            y1_reg     <= (cyh > XW'(cols_reg)) ? cols_reg : DIM_W'(cyh);
            walk_x_reg <= (cx_reg > DIM_W'(half_reg)) ? cx_reg - DIM_W'(half_reg) : DIM_W'(1);
            walk_y_reg <= (cy_reg > DIM_W'(half_reg)) ? cy_reg - DIM_W'(half_reg) : DIM_W'(1);
        end
        else if (emit)
        begin
            if (walk_y_reg == y1_reg)
            begin
                walk_y_reg <= y0_reg;
                walk_x_reg <= walk_x_reg + DIM_W'(1);
            end
            else
                walk_y_reg <= walk_y_reg + DIM_W'(1);
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= (state_reg == ST_WALK);
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm1_1_reg  <= walk_x_reg - DIM_W'(1);
            ym1_1_reg  <= walk_y_reg - DIM_W'(1);
            rows_1_reg <= rows_reg;
            tx_1_reg   <= SIZE_W'(tx_full);
            ty_1_reg   <= SIZE_W'(ty_full);
            size_1_reg <= size_reg;
            fin_1_reg  <= fin;

            prod_2_reg <= PROD_W'(ym1_1_reg) * PROD_W'(rows_1_reg);
            xm1_2_reg  <= xm1_1_reg;
            tap_2_reg  <= TAP_W'(ty_1_reg) * TAP_W'(size_1_reg) + TAP_W'(tx_1_reg);
            fin_2_reg  <= fin_1_reg;

            img_reg  <= IMG_W'(img_sum);
            tap_reg  <= tap_2_reg + TAP_W'(1);
            last_reg <= fin_2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({tap_reg, img_reg});
    assign m_tlast  = last_reg;

endmodule

// ===== tb/sv/cwig_checker.sv =====
`timescale 1ns / 1ps
// Checker for the clipped window index generator: predicts each window's index pairs and compares.
module cwig_checker #(
    parameter int MAX_FILTER_SIZE = 7,
    parameter int MAX_IMAGE_DIM   = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [cwig_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [cwig_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [cwig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cwig_pkg::CFG_W-1:0]     cfg_data,
    output int                             mismatches,
    output int                             pairs_left
);
    import cwig_pkg::*;

    typedef struct packed {
        img_t image_index;
        tap_t tap_index;
        logic last;
    } index_pair_t;

    index_pair_t      window_pairs[$];
    logic [CFG_W-1:0] image_rows;
    logic [CFG_W-1:0] image_cols;

    function automatic int dim_limit(logic [CFG_W-1:0] d);
        if (d == '0)
            return 1;
        if (int'(d) > MAX_IMAGE_DIM)
            return MAX_IMAGE_DIM;
        return int'(d);
    endfunction

    function automatic int clamp_centre(logic [COORD_IN_W-1:0] c, int lim);
        if (c == '0)
            return 1;
        if (int'(c) > lim)
            return lim;
        return int'(c);
    endfunction

    task automatic predict_window(input logic [S_DATA_W-1:0] word);
        int          rows;
        int          cols;
        int          side;
        int          half;
        int          cx;
        int          cy;
        int          x0;
        int          x1;
        int          y0;
        int          y1;
        int          x;
        int          y;
        int          img;
        int          tap;
        index_pair_t pair;
        rows = dim_limit(image_rows);
        cols = dim_limit(image_cols);
        side = int'(word[2*COORD_IN_W+SIZE_W-1:2*COORD_IN_W]);
        if (side < 1)
            side = 1;
        if (side > MAX_FILTER_SIZE)
            side = MAX_FILTER_SIZE;
        half = (side - 1) / 2;
        cx = clamp_centre(word[COORD_IN_W-1:0], rows);
        cy = clamp_centre(word[2*COORD_IN_W-1:COORD_IN_W], cols);
        x0 = (cx > half) ? cx - half : 1;
        x1 = (cx + half > rows) ? rows : cx + half;
        y0 = (cy > half) ? cy - half : 1;
        y1 = (cy + half > cols) ? cols : cy + half;
        for (x = x0; x <= x1; x++)
        begin
            for (y = y0; y <= y1; y++)
            begin
                img = (x - 1) + (y - 1) * rows + 1;
                tap = (cx + half - x) + (cy + half - y) * side + 1;
                pair.image_index = img[IMG_W-1:0];
                pair.tap_index   = tap[TAP_W-1:0];
                pair.last        = (x == x1) && (y == y1);
                window_pairs.push_back(pair);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        index_pair_t want;
        if (!rst_n)
        begin
            image_rows = CFG_W'(64);
            image_cols = CFG_W'(64);
            window_pairs.delete();
            pairs_left = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_ROWS: image_rows = cfg_data;
                    REG_IMAGE_COLS: image_cols = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_window(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (window_pairs.size() == 0)
                begin
                    $error("unexpected word: image_index %0d tap_index %0d last %0b",
                           m_tdata[IMG_W-1:0], m_tdata[IMG_W+TAP_W-1:IMG_W], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = window_pairs.pop_front();
                    if (m_tdata[IMG_W-1:0] !== want.image_index)
                    begin
                        $error("image_index: expected %0d, got %0d",
                               want.image_index, m_tdata[IMG_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[IMG_W+TAP_W-1:IMG_W] !== want.tap_index)
                    begin
                        $error("tap_index: expected %0d, got %0d",
                               want.tap_index, m_tdata[IMG_W+TAP_W-1:IMG_W]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            pairs_left = window_pairs.size();
        end
    end

endmodule

// ===== tb/sv/tb_clipped_window_index_generator.sv =====
`timescale 1ns / 1ps
// Testbench top for the clipped window index generator: stimulus, stalls and verdict.
module tb_clipped_window_index_generator;
    import cwig_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_WINDOWS = 48;
    localparam int HOLD_AT_WORD  = 1500;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pairs_left;
    int rows_eff;
    int cols_eff;
    int tx_calm;
    int rx_calm;
    int rx_words;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    clipped_window_index_generator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    cwig_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mismatches(mismatches),
        .pairs_left(pairs_left)
    );

    // centre: mostly inside, some at the borders, some anywhere in 11 bits
    function automatic logic [COORD_IN_W-1:0] pick_centre(int lim);
        int mode;
        int v;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            v = $urandom_range(1, lim);
        else if (mode < 8)
            v = $urandom_range(0, 1) ? $urandom_range(0, 3) : lim + 1 - $urandom_range(0, 3);
        else
            v = $urandom;
        return v[COORD_IN_W-1:0];
    endfunction

    task automatic send_window(input int cx, input int cy, input int side);
        int                  gap;
        logic [S_DATA_W-1:0] word;
        if (tx_calm > 0)
        begin
            gap = 0;
            tx_calm--;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            gap = 0;
            tx_calm = $urandom_range(10, 30);
        end
        else
            gap = $urandom_range(0, 11);
        word = '0;
        word[COORD_IN_W-1:0]                        = cx[COORD_IN_W-1:0];
        word[2*COORD_IN_W-1:COORD_IN_W]             = cy[COORD_IN_W-1:0];
        word[2*COORD_IN_W+SIZE_W-1:2*COORD_IN_W]    = side[SIZE_W-1:0];
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pairs_left != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_image(input int rows, input int cols);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_ROWS;
        cfg_data  <= rows[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= REG_IMAGE_COLS;
        cfg_data  <= cols[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        rows_eff = (rows == 0) ? 1 : ((rows > 1024) ? 1024 : rows);
        cols_eff = (cols == 0) ? 1 : ((cols > 1024) ? 1024 : cols);
    endtask

    // receiver: random stalls, calm runs, one long hold-off to back the block up
    initial
    begin : receiver
        int  gap;
        bit  held;
        m_tready <= 1'b0;
        rx_words = 0;
        rx_calm  = 0;
        held     = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!held && rx_words >= HOLD_AT_WORD)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            else if (rx_calm > 0)
            begin
                gap = 0;
                rx_calm--;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                gap = 0;
                rx_calm = $urandom_range(20, 80);
            end
            else
                gap = $urandom_range(0, 11);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            rx_words++;
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #6000000;
        $display("tb_clipped_window_index_generator: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int rows_tab [PHASES];
        int cols_tab [PHASES];
        int p;
        int i;
        int w;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_IMAGE_ROWS;
        cfg_data  = '0;
        tx_calm   = 0;
        rows_eff  = 64;
        cols_eff  = 64;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset image size
        send_window(1, 1, 3);
        send_window(64, 64, 3);
        send_window(32, 32, 7);
        send_window(32, 32, 0);
        send_window(32, 32, 1);
        send_window(32, 32, 2);
        send_window(32, 32, 4);
        send_window(32, 32, 6);
        send_window(10, 20, 5);
        send_window(0, 0, 7);
        send_window(2047, 2047, 7);
        send_window(1, 64, 7);
        send_window(64, 1, 6);
        send_window(2047, 0, 4);
        send_window(2, 63, 5);
        wait_idle();

        // zero extent behaves as one
        set_image(0, 0);
        send_window(1, 1, 7);
        send_window(2047, 2047, 3);
        wait_idle();

        // oversize extent behaves as the maximum; widest image index
        set_image(2047, 2047);
        send_window(1024, 1024, 7);
        send_window(2047, 2047, 7);
        send_window(1, 1024, 7);
        send_window(1024, 1, 2);
        wait_idle();

        set_image(1024, 1);
        send_window(500, 1, 7);
        send_window(1024, 7, 5);
        wait_idle();

        rows_tab = '{1024, 1, 2, 7, 2047, 0};
        cols_tab = '{1024, 1, 9, 3, 1025, 0};
        rows_tab[PHASES-1] = $urandom_range(1, 40);
        cols_tab[PHASES-1] = $urandom_range(1, 40);
        for (p = 0; p < PHASES; p++)
        begin
            set_image(rows_tab[p], cols_tab[p]);
            for (i = 0; i < PHASE_WINDOWS; i++)
                send_window(int'(pick_centre(rows_eff)), int'(pick_centre(cols_eff)),
                            $urandom_range(0, 7));
            wait_idle();
        end

        for (w = 0; w < DRAIN_LIMIT && pairs_left != 0; w++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0 && pairs_left == 0)
            $display("tb_clipped_window_index_generator: PASS");
        else
            $display("tb_clipped_window_index_generator: FAIL");
        $finish;
    end

endmodule
